FILE: sv/sfdr_pkg.sv
// ----------------------------------------------------------------------------
// sfdr_pkg
// Types and constants shared by the set-filtered duplicate removal block.
// ----------------------------------------------------------------------------
package sfdr_pkg;

  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned COUNT_BITS = 16;

  // request mode codes
  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_LOAD   = 2'd1;
  localparam logic [1:0] MODE_FILTER = 2'd2;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_CLEAR,
    OP_LOAD,
    OP_FILTER
  } sfdr_op_e;

  typedef struct packed {
    logic [1:0]                   mode;
    logic signed [VALUE_BITS-1:0] value;
    logic                         last;
  } sfdr_req_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] element;
    logic                         keep;
    logic [COUNT_BITS-1:0]        kept_count;
    logic [COUNT_BITS-1:0]        removed_count;
    logic                         set_overflow;
    logic                         is_last;
  } sfdr_rsp_t;

  // token that walks the cell chain
  typedef struct packed {
    sfdr_op_e                op;
    logic [VALUE_BITS-1:0]   value;
    logic                    last;
    logic                    done;  // placed (load) or matched (filter)
    logic                    keep;
  } sfdr_tok_t;

endpackage

FILE: sv/sfdr_cell.sv
// ----------------------------------------------------------------------------
// sfdr_cell
// One set entry with its valid bit and seen mark; forwards the token.
// ----------------------------------------------------------------------------
module sfdr_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  sfdr_pkg::sfdr_tok_t  tok_i,
  output sfdr_pkg::sfdr_tok_t  tok_o
);

  logic [sfdr_pkg::VALUE_BITS-1:0] val_q, val_d;
  logic                            vld_q, vld_d;
  logic                            seen_q, seen_d;
  sfdr_pkg::sfdr_tok_t             tok_q, tok_d;
  logic                            hit;
  logic                            free;

  assign hit  = vld_q && (val_q == tok_i.value) && !tok_i.done;
  assign free = !vld_q && !tok_i.done;

  always_comb begin
    tok_d  = tok_i;
    val_d  = val_q;
    vld_d  = vld_q;
    seen_d = seen_q;
    case (tok_i.op)
      sfdr_pkg::OP_CLEAR: begin
        vld_d  = 1'b0;
        seen_d = 1'b0;
      end
      sfdr_pkg::OP_LOAD: begin
        if (free) begin
          val_d      = tok_i.value;
          vld_d      = 1'b1;
          tok_d.done = 1'b1;
        end
      end
      sfdr_pkg::OP_FILTER: begin
        if (hit) begin
          tok_d.done = 1'b1;
          tok_d.keep = !seen_q;
          seen_d     = 1'b1;
        end
        // end of sequence: drop the mark once this element has passed
        if (tok_i.last) begin
          seen_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      seen_q <= 1'b0;
      tok_q  <= '0;
    end else if (advance_i) begin
      vld_q  <= vld_d;
      seen_q <= seen_d;
      tok_q  <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      val_q <= val_d;
    end
  end

  assign tok_o = tok_q;

  a_seen_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q |-> !seen_q)
    else $error("seen mark set on an empty entry");

endmodule

FILE: sv/sfdr_tail.sv
// ----------------------------------------------------------------------------
// sfdr_tail
// End of the chain: running counts, overflow flag and the output register.
// ----------------------------------------------------------------------------
module sfdr_tail (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sfdr_pkg::sfdr_tok_t  tok_i,
  input  logic                 stall_i,
  output logic                 advance_o,
  output logic                 out_valid_o,
  output sfdr_pkg::sfdr_rsp_t  out_o
);

  logic [sfdr_pkg::COUNT_BITS-1:0] kept_q, kept_d, kept_n;
  logic [sfdr_pkg::COUNT_BITS-1:0] rem_q, rem_d, rem_n;
  logic                            ovf_q, ovf_d;
  logic                            out_valid_q, out_valid_d;
  sfdr_pkg::sfdr_rsp_t             out_q, out_d;
  logic                            advance;

  assign advance   = !out_valid_q || !stall_i;
  assign advance_o = advance;

  always_comb begin
    kept_n = kept_q;
    rem_n  = rem_q;
    if (tok_i.keep) begin
      kept_n = (kept_q == '1) ? kept_q : kept_q + {{(sfdr_pkg::COUNT_BITS-1){1'b0}}, 1'b1};
    end else begin
      rem_n = (rem_q == '1) ? rem_q : rem_q + {{(sfdr_pkg::COUNT_BITS-1){1'b0}}, 1'b1};
    end
  end

  always_comb begin
    kept_d            = kept_q;
    rem_d             = rem_q;
    ovf_d             = ovf_q;
    out_valid_d       = out_valid_q;
    out_d             = out_q;
    out_d.element     = tok_i.value;
    out_d.keep        = tok_i.keep;
    out_d.kept_count  = kept_n;
    out_d.removed_count = rem_n;
    out_d.set_overflow  = ovf_q;
    out_d.is_last       = tok_i.last;
    if (advance) begin
      out_valid_d = (tok_i.op == sfdr_pkg::OP_FILTER);
      case (tok_i.op)
        sfdr_pkg::OP_CLEAR: begin
          kept_d = '0;
          rem_d  = '0;
          ovf_d  = 1'b0;
        end
        sfdr_pkg::OP_LOAD: begin
          // a load that found no free entry was dropped
          if (!tok_i.done) begin
            ovf_d = 1'b1;
          end
        end
        sfdr_pkg::OP_FILTER: begin
          kept_d = tok_i.last ? '0 : kept_n;
          rem_d  = tok_i.last ? '0 : rem_n;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_q      <= '0;
      rem_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      kept_q      <= kept_d;
      rem_q       <= rem_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_keep_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.keep |-> out_q.kept_count != '0)
    else $error("kept element with zero kept count");

  a_drop_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.keep |-> out_q.removed_count != '0)
    else $error("removed element with zero removed count");

  a_clear_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && tok_i.op == sfdr_pkg::OP_CLEAR |=> !ovf_q)
    else $error("overflow flag survived a clear");

  a_filter_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && tok_i.op == sfdr_pkg::OP_FILTER |=> out_valid_q)
    else $error("filter request produced no result");

endmodule

FILE: sv/set_filtered_duplicate_removal.sv
// ----------------------------------------------------------------------------
// set_filtered_duplicate_removal
// Reference set held in a chain of cells; stream elements keep only the first
// copy of each set member per sequence.
//
//   port group        dir  handshake              payload
//   in_*              in   in_valid_i/in_stall_o   sfdr_req_t (mode,value,last)
//   out_*             out  out_valid_o/out_stall_i sfdr_rsp_t
//
// A request walks the SET_DEPTH cells in order, then the output register.
// One request per cycle sustained while no stalled result is held at the output.
// A stalled result freezes the whole chain and stalls the input.
// Reset empties every cell at once; no clearing pass.
// ----------------------------------------------------------------------------
module set_filtered_duplicate_removal #(
  parameter int unsigned SET_DEPTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sfdr_pkg::sfdr_req_t  in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sfdr_pkg::sfdr_rsp_t  out_rsp_o
);

  sfdr_pkg::sfdr_tok_t tok [SET_DEPTH+1];
  sfdr_pkg::sfdr_tok_t head;
  logic                advance;

  assign in_stall_o = !advance;

  // decode the request into a chain token
  always_comb begin
    head       = '0;
    head.op    = sfdr_pkg::OP_NOP;
    head.value = in_req_i.value;
    head.last  = in_req_i.last;
    head.done  = 1'b0;
    head.keep  = 1'b1;
    if (in_valid_i) begin
      unique case (in_req_i.mode)
        sfdr_pkg::MODE_CLEAR:  head.op = sfdr_pkg::OP_CLEAR;
        sfdr_pkg::MODE_LOAD:   head.op = sfdr_pkg::OP_LOAD;
        sfdr_pkg::MODE_FILTER: head.op = sfdr_pkg::OP_FILTER;
        default:               head.op = sfdr_pkg::OP_NOP;
      endcase
    end
  end

  assign tok[0] = head;

  for (genvar g = 0; g < SET_DEPTH; g++) begin : g_cell
    sfdr_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .tok_i     (tok[g]),
      .tok_o     (tok[g+1])
    );
  end

  sfdr_tail u_tail (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_i       (tok[SET_DEPTH]),
    .stall_i     (out_stall_i),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_o       (out_rsp_o)
  );

endmodule
